[sv/tlmmg_pkg.sv]
`timescale 1ns / 1ps

package tlmmg_pkg;

  localparam int LIST_DEPTH = 1024;

  localparam int VALUE_W = 32;
  localparam int GAP_W   = 32;
  localparam int OP_W    = 2;
  localparam int ERR_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD_ONE   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TWO   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_THREE = 2'd2;
  localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd3;

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic eval;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic any_empty;
    logic last_step;
    logic out_busy;
  } sts_t;

endpackage

[sv/tlmmg_ram.sv]
`timescale 1ns / 1ps

module tlmmg_ram #(
  parameter int WIDTH = tlmmg_pkg::VALUE_W,
  parameter int DEPTH = tlmmg_pkg::LIST_DEPTH
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/tlmmg_ctrl.sv]
`timescale 1ns / 1ps

module tlmmg_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_valid,
  input  logic [tlmmg_pkg::OP_W-1:0]  s_op,
  output logic                        s_ready,
  input  tlmmg_pkg::sts_t             sts,
  output tlmmg_pkg::cmd_t             cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_EVAL   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_compute;

  assign is_compute = (s_op == tlmmg_pkg::OP_COMPUTE);
  assign s_ready    = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          if (is_compute) begin
            cmd.start  = 1'b1;
            state_next = sts.any_empty ? S_FINISH : S_READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.last_step ? S_DRAIN : S_READ;
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/tlmmg_dp.sv]
`timescale 1ns / 1ps

module tlmmg_dp #(
  parameter int LIST_DEPTH = tlmmg_pkg::LIST_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tlmmg_pkg::cmd_t                cmd,
  output tlmmg_pkg::sts_t                sts,
  input  logic [tlmmg_pkg::OP_W-1:0]     in_op,
  input  logic [tlmmg_pkg::VALUE_W-1:0]  in_value,
  input  logic                           m_ready,
  output logic                           m_valid,
  output logic [tlmmg_pkg::GAP_W-1:0]    m_gap,
  output logic [tlmmg_pkg::ERR_W-1:0]    m_err
);

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);
  localparam int VW = tlmmg_pkg::VALUE_W;

  logic [CNT_W-1:0] cnt_one, cnt_two, cnt_three;
  logic [CNT_W-1:0] ptr_one, ptr_two, ptr_three;
  logic [CNT_W-1:0] ptr_one_inc, ptr_two_inc, ptr_three_inc;
  logic             ovf;
  logic             empty_err;
  logic             we_one, we_two, we_three;
  logic             full_sel;
  logic             last_step;

  logic signed [VW-1:0] a, b, c;
  logic signed [VW-1:0] lo, hi;
  logic                 sel_a, sel_b;
  logic        [VW:0]   diff_wide;
  logic [tlmmg_pkg::GAP_W-1:0] diff, diff_q, best;
  logic                 diff_valid;

  // list writes
  always_comb begin
    we_one   = 1'b0;
    we_two   = 1'b0;
    we_three = 1'b0;
    full_sel = 1'b0;
    unique case (in_op)
      tlmmg_pkg::OP_LOAD_ONE: begin
        full_sel = (cnt_one == FULL);
        we_one   = cmd.load && !full_sel;
      end
      tlmmg_pkg::OP_LOAD_TWO: begin
        full_sel = (cnt_two == FULL);
        we_two   = cmd.load && !full_sel;
      end
      tlmmg_pkg::OP_LOAD_THREE: begin
        full_sel = (cnt_three == FULL);
        we_three = cmd.load && !full_sel;
      end
      default: begin
        full_sel = 1'b0;
      end
    endcase
  end

  tlmmg_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_ram_one (
    .clk   (clk),
    .we    (we_one),
    .waddr (cnt_one[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (ptr_one[ADDR_W-1:0]),
    .rdata (a)
  );

  tlmmg_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_ram_two (
    .clk   (clk),
    .we    (we_two),
    .waddr (cnt_two[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (ptr_two[ADDR_W-1:0]),
    .rdata (b)
  );

  tlmmg_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_ram_three (
    .clk   (clk),
    .we    (we_three),
    .waddr (cnt_three[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (ptr_three[ADDR_W-1:0]),
    .rdata (c)
  );

  // merge step: smallest head advances, ties go to the earlier list
  assign sel_a = (a <= b) && (a <= c);
  assign sel_b = !sel_a && (b <= c);

  always_comb begin
    if (sel_a) begin
      lo = a;
    end else if (sel_b) begin
      lo = b;
    end else begin
      lo = c;
    end
    if ((a >= b) && (a >= c)) begin
      hi = a;
    end else if (b >= c) begin
      hi = b;
    end else begin
      hi = c;
    end
  end

  assign diff_wide = {hi[VW-1], hi} - {lo[VW-1], lo};
  assign diff      = diff_wide[tlmmg_pkg::GAP_W-1:0];

  assign ptr_one_inc   = ptr_one + CNT_W'(1);
  assign ptr_two_inc   = ptr_two + CNT_W'(1);
  assign ptr_three_inc = ptr_three + CNT_W'(1);

  always_comb begin
    if (sel_a) begin
      last_step = (ptr_one_inc >= cnt_one);
    end else if (sel_b) begin
      last_step = (ptr_two_inc >= cnt_two);
    end else begin
      last_step = (ptr_three_inc >= cnt_three);
    end
  end

  assign sts.last_step = last_step;
  assign sts.any_empty = (cnt_one == '0) || (cnt_two == '0) || (cnt_three == '0);
  assign sts.out_busy  = m_valid && !m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_one    <= '0;
      cnt_two    <= '0;
      cnt_three  <= '0;
      ovf        <= 1'b0;
      diff_valid <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      if (cmd.load && full_sel) begin
        ovf <= 1'b1;
      end
      if (we_one) begin
        cnt_one <= cnt_one + CNT_W'(1);
      end
      if (we_two) begin
        cnt_two <= cnt_two + CNT_W'(1);
      end
      if (we_three) begin
        cnt_three <= cnt_three + CNT_W'(1);
      end
      if (cmd.finish) begin
        cnt_one   <= '0;
        cnt_two   <= '0;
        cnt_three <= '0;
        ovf       <= 1'b0;
      end
      diff_valid <= cmd.eval;
      if (cmd.finish) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr_one   <= '0;
      ptr_two   <= '0;
      ptr_three <= '0;
      best      <= '1;
      empty_err <= sts.any_empty;
    end
    if (cmd.eval) begin
      diff_q <= diff;
      if (sel_a) begin
        ptr_one <= ptr_one_inc;
      end else if (sel_b) begin
        ptr_two <= ptr_two_inc;
      end else begin
        ptr_three <= ptr_three_inc;
      end
    end
    if (diff_valid && (diff_q < best)) begin
      best <= diff_q;
    end
    if (cmd.finish) begin
      m_gap <= empty_err ? '0 : best;
      if (empty_err) begin
        m_err <= tlmmg_pkg::ERR_EMPTY;
      end else if (ovf) begin
        m_err <= tlmmg_pkg::ERR_OVERFLOW;
      end else begin
        m_err <= tlmmg_pkg::ERR_OK;
      end
    end
  end

endmodule

[sv/three_list_min_max_gap_unit.sv]
`timescale 1ns / 1ps

// channel   direction  tdata                  tuser
// s_axis    in         value [31:0] signed    operation [1:0]
// m_axis    out        min_max_gap [31:0]     error [1:0]
//
// loads may follow back to back, also while a result waits
// compute: each merge step is S_READ over the ram read port, then S_EVAL, at most
// n1+n2+n3-2 steps, then S_DRAIN and S_FINISH; input reopens with the result beat
// with an empty list the compute skips the merge and goes straight to S_FINISH
// a compute holds in its last state while the output register is still full
// reset clears the list counts, the overflow flag and the output valid; no memory sweep

module three_list_min_max_gap_unit #(
  parameter int LIST_DEPTH = tlmmg_pkg::LIST_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tlmmg_pkg::VALUE_W-1:0] s_axis_tdata,  // value
  input  logic [tlmmg_pkg::OP_W-1:0]    s_axis_tuser,  // operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tlmmg_pkg::GAP_W-1:0]   m_axis_tdata,  // min_max_gap
  output logic [tlmmg_pkg::ERR_W-1:0]   m_axis_tuser   // error
);

  tlmmg_pkg::cmd_t cmd;
  tlmmg_pkg::sts_t sts;

  tlmmg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_op    (s_axis_tuser),
    .s_ready (s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tlmmg_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (s_axis_tuser),
    .in_value (s_axis_tdata),
    .m_ready  (m_axis_tready),
    .m_valid  (m_axis_tvalid),
    .m_gap    (m_axis_tdata),
    .m_err    (m_axis_tuser)
  );

endmodule

[sv/tlmmg_checker.sv]
`timescale 1ns / 1ps

module tlmmg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [tlmmg_pkg::OP_W-1:0]    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tlmmg_pkg::GAP_W-1:0]   m_axis_tdata,
  input logic [tlmmg_pkg::ERR_W-1:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == tlmmg_pkg::ERR_OK) ||
      (m_axis_tuser == tlmmg_pkg::ERR_EMPTY) || (m_axis_tuser == tlmmg_pkg::ERR_OVERFLOW))
    else $error("unknown error code");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == tlmmg_pkg::ERR_EMPTY) |-> m_axis_tdata == '0)
    else $error("empty list result with nonzero gap");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == tlmmg_pkg::OP_COMPUTE)
      |=> !s_axis_tready)
    else $error("input taken right after a compute beat");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind three_list_min_max_gap_unit tlmmg_checker u_tlmmg_checker (.*);
